// File: rtl/eps_pkg.sv
// Package for the EEPROM page write splitter: payload types, codes and limits.
`default_nettype none

package eps_pkg;

  localparam int unsigned AddrW    = 16;
  localparam int unsigned CountW   = 9;
  localparam int unsigned PageW    = 9;
  localparam int unsigned DevW     = 17;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned DivCntW  = $clog2(AddrW);

  localparam logic [PageW-1:0]  PageMin    = 9'd8;
  localparam logic [PageW-1:0]  PageMax    = 9'd256;
  localparam logic [PageW-1:0]  PageReset  = 9'd64;
  localparam logic [DevW-1:0]   DevReset   = 17'd32768;
  localparam logic [DevW-1:0]   DevLimit   = 17'h10000;
  localparam logic [CountW-1:0] MaxRequest = 9'd256;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPageBytes   = 1'b0,
    CfgDeviceBytes = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StDivide,
    StEmit
  } state_e;

  typedef struct packed {
    logic              mode;
    logic [AddrW-1:0]  start_address;
    logic [CountW-1:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0]  segment_address;
    logic [CountW-1:0] buffer_offset;
    logic [CountW-1:0] segment_length;
    logic              is_write;
    logic              status;
    logic              last;
  } seg_t;

  typedef struct packed {
    cfg_idx_e        reg_index;
    logic [DevW-1:0] write_data;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad;
    logic write;
    logic div_last;
    logic seg_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/eps_req_if.sv
// Request channel: one EEPROM request per transfer.
`default_nettype none

interface eps_req_if;
  logic          valid;
  logic          ready;
  eps_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/eps_seg_if.sv
// Segment channel: one result segment per transfer.
`default_nettype none

interface eps_seg_if;
  logic          valid;
  logic          ready;
  eps_pkg::seg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/eps_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface eps_cfg_if;
  logic          valid;
  logic          ready;
  eps_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/eps_ctrl.sv
// Controller state machine of the EEPROM page write splitter.
`default_nettype none

module eps_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire eps_pkg::sts_t sts_i,
  output eps_pkg::cmd_t      cmd_o
);

  eps_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eps_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      eps_pkg::StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = eps_pkg::StCheck;
        end
      end
      eps_pkg::StCheck: begin
        cmd_o.prep = 1'b1;
        if (!sts_i.bad && sts_i.write) begin
          state_d = eps_pkg::StDivide;
        end else begin
          state_d = eps_pkg::StEmit;
        end
      end
      eps_pkg::StDivide: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = eps_pkg::StEmit;
        end
      end
      eps_pkg::StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.seg_last) begin
            state_d = eps_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = eps_pkg::StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/eps_dp.sv
// Datapath: config registers, range check, offset-in-page divider, segment walk.
`default_nettype none

module eps_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  input  wire eps_pkg::cfg_t cfg_i,
  input  wire eps_pkg::req_t req_i,
  input  wire logic          seg_ready_i,
  output logic               seg_valid_o,
  output eps_pkg::seg_t      seg_o,
  input  wire eps_pkg::cmd_t cmd_i,
  output eps_pkg::sts_t      sts_o
);

  localparam int unsigned AW = eps_pkg::AddrW;
  localparam int unsigned CW = eps_pkg::CountW;
  localparam int unsigned PW = eps_pkg::PageW;
  localparam int unsigned DW = eps_pkg::DevW;
  localparam int unsigned NW = eps_pkg::DivCntW;

  logic [PW-1:0] page_q;
  logic [DW-1:0] dev_q;

  logic          mode_q;
  logic [AW-1:0] addr_q;
  logic [CW-1:0] size_q;
  logic          invalid_q;

  logic [AW-1:0] div_sh_q;
  logic [NW-1:0] div_cnt_q;
  logic [PW-1:0] rem_q;

  logic [AW-1:0] seg_addr_q;
  logic [CW-1:0] pos_q;
  logic [CW-1:0] left_q;
  logic [CW-1:0] room_q;

  logic          out_valid_q;
  eps_pkg::seg_t out_q;

  logic [DW-1:0] dev_eff;
  logic [DW-1:0] addr_end;
  logic          bad;
  logic [PW:0]   rem_sh;
  logic [PW:0]   rem_nx;
  logic [CW-1:0] seg_len;
  logic          seg_last;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= eps_pkg::PageReset;
      dev_q  <= eps_pkg::DevReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_i.reg_index)
        eps_pkg::CfgPageBytes:   page_q <= cfg_i.write_data[PW-1:0];
        eps_pkg::CfgDeviceBytes: dev_q  <= cfg_i.write_data;
        default: ;
      endcase
    end
  end

  // range check
  always_comb begin
    dev_eff  = (dev_q > eps_pkg::DevLimit) ? eps_pkg::DevLimit : dev_q;
    addr_end = {1'b0, addr_q} + DW'(size_q);
    bad      = (dev_eff == '0) || (page_q < eps_pkg::PageMin) ||
               (page_q > eps_pkg::PageMax) || (size_q > eps_pkg::MaxRequest) ||
               (addr_end > dev_eff);
  end

  // one restoring step of start_address mod page
  always_comb begin
    rem_sh = {rem_q, div_sh_q[AW-1]};
    rem_nx = (rem_sh >= {1'b0, page_q}) ? (rem_sh - {1'b0, page_q}) : rem_sh;
  end

  always_comb begin
    seg_len  = (left_q < room_q) ? left_q : room_q;
    seg_last = (left_q <= room_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= req_i.mode;
      addr_q <= req_i.start_address;
      size_q <= req_i.byte_count;
    end
    if (cmd_i.prep) begin
      invalid_q  <= bad;
      left_q     <= bad ? '0 : size_q;
      room_q     <= '1;             // wider than any request: single segment
      pos_q      <= '0;
      seg_addr_q <= addr_q;
      div_sh_q   <= addr_q;
      rem_q      <= '0;
    end
    if (cmd_i.div_step) begin
      div_sh_q <= div_sh_q << 1;
      rem_q    <= rem_nx[PW-1:0];
      room_q   <= page_q - rem_nx[PW-1:0];
    end
    if (cmd_i.emit) begin
      out_q.segment_address <= seg_addr_q;
      out_q.buffer_offset   <= pos_q;
      out_q.segment_length  <= seg_len;
      out_q.is_write        <= mode_q;
      out_q.status          <= invalid_q;
      out_q.last            <= seg_last;
      seg_addr_q            <= seg_addr_q + AW'(seg_len);
      pos_q                 <= pos_q + seg_len;
      left_q                <= left_q - seg_len;
      room_q                <= page_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.prep) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (seg_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign seg_valid_o = out_valid_q;
  assign seg_o       = out_q;

  always_comb begin
    sts_o          = '0;
    sts_o.bad      = bad;
    sts_o.write    = mode_q;
    sts_o.div_last = (div_cnt_q == NW'(AW - 1));
    sts_o.seg_last = seg_last;
    sts_o.out_free = !out_valid_q || seg_ready_i;
  end

  // a rejected request always reports an empty, final segment
  a_invalid_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status |-> (out_q.segment_length == '0) && out_q.last)
    else $error("invalid result with nonzero length or not last");

  // a valid write segment is never longer than a page
  a_write_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.is_write && !out_q.status |->
      (out_q.segment_length <= page_q))
    else $error("write segment longer than a page");

  // the walk never takes more bytes than remain
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (seg_len <= left_q))
    else $error("segment length exceeds remaining bytes");

  // the remainder stays below the page size during the division
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (rem_q < page_q))
    else $error("page offset not reduced");

endmodule

`default_nettype wire

// File: rtl/eeprom_page_write_splitter.sv
// Top level of the EEPROM page write splitter.
// Usage:
//  - req_i takes one request per transfer: mode (0 read, 1 write), start_address
//    and byte_count. It is ready only while no request is being worked on.
//  - seg_o gives the result segments in order, one per transfer; the last
//    segment of a request carries last = 1. A rejected request gives a single
//    segment with status 1 and length 0.
//  - cfg_i writes page_bytes (index 0) or device_bytes (index 1). It is always
//    ready; write only while the block is idle.
// Sequence:
//  - A read or rejected request: accept, check, then emit loads its one segment
//    into the output register that drives seg_o.
//  - A valid write: accept, check, then a bit-serial start_address mod page_bytes
//    (one address bit a cycle), then one segment per cycle while seg_o does not
//    stall, up to 33 segments.
//  - The output register decouples the sides: the next request is taken while
//    the final segment of the previous one still waits on seg_o.
// A stall on seg_o holds the walk; nothing is dropped. Reset returns the
// controller to idle, empties the output register and restores page_bytes = 64
// and device_bytes = 32768.
`default_nettype none

module eeprom_page_write_splitter (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  eps_req_if.sink    req_i,
  eps_seg_if.source  seg_o,
  eps_cfg_if.sink    cfg_i
);

  eps_pkg::cmd_t cmd;
  eps_pkg::sts_t sts;
  logic          req_ready;
  logic          seg_valid;
  eps_pkg::seg_t seg_data;

  // registers are plain flops, so a write is taken every cycle
  assign cfg_i.ready = 1'b1;
  assign req_i.ready = req_ready;
  assign seg_o.valid = seg_valid;
  assign seg_o.data  = seg_data;

  eps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  eps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_i       (cfg_i.data),
    .req_i       (req_i.data),
    .seg_ready_i (seg_o.ready),
    .seg_valid_o (seg_valid),
    .seg_o       (seg_data),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire
